/* hdl/chbb_pkg.sv */
`timescale 1ns / 1ps
package chbb_pkg;

  localparam int unsigned DegFull   = 360;
  localparam int unsigned DigitLow  = 48;
  localparam int unsigned DigitHigh = 57;
  localparam int unsigned AccMax    = 999;

  localparam logic [1:0] CfgTargetHeading = 2'd0;
  localparam logic [1:0] CfgDeadbandLimit = 2'd1;
  localparam logic [1:0] CfgHalfTurnLimit = 2'd2;

  localparam logic [8:0] TargetReset   = 9'd230;
  localparam logic [7:0] DeadbandReset = 8'd3;
  localparam logic [7:0] HalfTurnReset = 8'd20;

  typedef enum logic [2:0] {
    CMD_STRAIGHT   = 3'd0,
    CMD_RIGHT_HALF = 3'd1,
    CMD_RIGHT_FULL = 3'd2,
    CMD_LEFT_HALF  = 3'd3,
    CMD_LEFT_FULL  = 3'd4
  } steer_cmd_t;

  typedef struct packed {
    logic [8:0] target_heading;
    logic [7:0] deadband_limit;
    logic [7:0] half_turn_limit;
  } cfg_t;

  typedef struct packed {
    logic       heading_updated;
    logic       range_fault;
    logic [8:0] current_heading;
  } parse_result_t;

  function automatic logic [3:0] relay_of_cmd(steer_cmd_t cmd);
    logic [3:0] bits;
    unique case (cmd)
      CMD_STRAIGHT:   bits = 4'hA;
      CMD_RIGHT_HALF: bits = 4'h8;
      CMD_RIGHT_FULL: bits = 4'h9;
      CMD_LEFT_HALF:  bits = 4'h2;
      CMD_LEFT_FULL:  bits = 4'h6;
      default:        bits = 4'hA;
    endcase
    return bits;
  endfunction

endpackage

/* hdl/chbb_parser.sv */
`timescale 1ns / 1ps
module chbb_parser (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             rx_byte,
  output logic                   res_valid,
  input  logic                   res_ready,
  output chbb_pkg::parse_result_t res_data
);
  import chbb_pkg::*;

  logic       parsing_number;
  logic [9:0] digit_accumulator;
  logic [8:0] latched_heading;

  logic       parsing_number_next;
  logic [9:0] digit_accumulator_next;
  logic [8:0] latched_heading_next;
  logic       updated;
  logic       fault;

  logic       is_digit;
  logic [3:0] digit;
  logic [13:0] extended;

  assign in_ready = !res_valid || res_ready;
  assign is_digit = (rx_byte >= 8'(DigitLow)) && (rx_byte <= 8'(DigitHigh));
  assign digit    = 4'(rx_byte - 8'(DigitLow));
  assign extended = 14'(digit_accumulator) * 14'd10 + 14'(digit);

  always_comb begin
    parsing_number_next    = parsing_number;
    digit_accumulator_next = digit_accumulator;
    latched_heading_next   = latched_heading;
    updated                = 1'b0;
    fault                  = 1'b0;
    if (!parsing_number) begin
      if (is_digit) begin
        parsing_number_next    = 1'b1;
        digit_accumulator_next = 10'(digit);
      end
    end else if (is_digit) begin
      if (extended > 14'(AccMax)) begin
        digit_accumulator_next = 10'(AccMax);
      end else begin
        digit_accumulator_next = extended[9:0];
      end
    end else begin
      parsing_number_next = 1'b0;
      if (digit_accumulator < 10'(DegFull)) begin
        latched_heading_next = digit_accumulator[8:0];
        updated              = 1'b1;
      end else begin
        fault = 1'b1;
      end
      digit_accumulator_next = 10'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parsing_number    <= 1'b0;
      digit_accumulator <= 10'd0;
      latched_heading   <= 9'd0;
      res_valid         <= 1'b0;
    end else if (in_ready) begin
      res_valid <= in_valid;
      if (in_valid) begin
        parsing_number    <= parsing_number_next;
        digit_accumulator <= digit_accumulator_next;
        latched_heading   <= latched_heading_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      res_data.heading_updated <= updated;
      res_data.range_fault     <= fault;
      res_data.current_heading <= latched_heading_next;
    end
  end

endmodule

/* hdl/chbb_steer.sv */
`timescale 1ns / 1ps
module chbb_steer (
  input  logic                   clk,
  input  logic                   rst,
  input  chbb_pkg::cfg_t         cfg,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  chbb_pkg::parse_result_t in_data,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [31:0]            m_axis_tdata
);
  import chbb_pkg::*;

  logic [8:0]        tgt;
  logic signed [9:0] diff;
  logic signed [9:0] err;
  logic signed [9:0] dead_pos;
  logic signed [9:0] half_pos;
  steer_cmd_t        cmd;

  assign in_ready = !m_axis_tvalid || m_axis_tready;

  assign tgt  = (cfg.target_heading >= 9'(DegFull)) ?
                9'(cfg.target_heading - 9'(DegFull)) : cfg.target_heading;
  assign diff = $signed({1'b0, in_data.current_heading}) - $signed({1'b0, tgt});

  always_comb begin
    if (diff <= -10'sd180) begin
      err = diff + 10'sd360;
    end else if (diff > 10'sd180) begin
      err = diff - 10'sd360;
    end else begin
      err = diff;
    end
  end

  assign dead_pos = $signed({2'b00, cfg.deadband_limit});
  assign half_pos = $signed({2'b00, cfg.half_turn_limit});

  // The first matching check of the ordered list wins; the tests run from first to last.
  always_comb begin
    priority if (err > half_pos) begin
      cmd = CMD_LEFT_FULL;
    end else if (err > dead_pos && err <= half_pos) begin
      cmd = CMD_LEFT_HALF;
    end else if (err < -half_pos) begin
      cmd = CMD_RIGHT_FULL;
    end else if (err < -dead_pos && err >= -half_pos) begin
      cmd = CMD_RIGHT_HALF;
    end else begin
      cmd = CMD_STRAIGHT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (in_ready) begin
      m_axis_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      m_axis_tdata <= {5'd0, relay_of_cmd(cmd), cmd, err[8:0],
                       in_data.current_heading, in_data.range_fault,
                       in_data.heading_updated};
    end
  end

endmodule

/* hdl/compass_heading_bang_bang_steering.sv */
`timescale 1ns / 1ps
// Compass heading bang-bang steering.
// Bytes from the compass link enter on the s_axis channel, one per transaction.
// Every accepted byte yields exactly one result transaction on m_axis, in order.
// A run of ASCII digits is gathered in decimal and, if below 360, latched as
// the heading when the first non-digit arrives; each result carries the
// latched heading, the shortest-way error to the target and the relay drive
// command. Each accepted byte passes the parser register, then the steering
// output register. A new byte is accepted in every cycle while the receiver
// takes results, so throughput is one item per cycle.
// When the receiver stalls, results wait in the two registers and s_axis_tready
// falls once both are full; no transaction is lost or repeated.
// The cfg port writes the target heading, deadband limit and half-turn limit
// at any edge with cfg_we high; writes are to be made while the block is idle,
// a rule for the user that the block itself does not enforce.
// Synchronous reset clears the parser, the heading and both stages, and
// restores the default target and limits.
module compass_heading_bang_bang_steering (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] heading_updated, [1] range_fault, [10:2] current_heading,
  // [19:11] heading_error, [22:20] steer_command, [26:23] relay_bits, [31:27] zero
  output logic [31:0] m_axis_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data
);
  import chbb_pkg::*;

  cfg_t          cfg;
  logic          res_valid;
  logic          res_ready;
  parse_result_t res_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_heading  <= TargetReset;
      cfg.deadband_limit  <= DeadbandReset;
      cfg.half_turn_limit <= HalfTurnReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgTargetHeading: cfg.target_heading  <= cfg_data;
        CfgDeadbandLimit: cfg.deadband_limit  <= cfg_data[7:0];
        CfgHalfTurnLimit: cfg.half_turn_limit <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  chbb_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .rx_byte   (s_axis_tdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

  chbb_steer u_steer (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (res_valid),
    .in_ready      (res_ready),
    .in_data       (res_data),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule
